// ===== sv/ccss_pkg.sv =====
// ----------------------------------------------------------------------------
// ccss_pkg
// shared types and constants for the charlieplexed seven-segment scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccss_pkg;

  localparam int unsigned SEG_W   = 8;
  localparam int unsigned PORT_W  = 8;
  localparam int unsigned PHASE_W = 3;

  // scan phases, anode first then cathode
  localparam logic [PHASE_W-1:0] PH_CA1 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CA3 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CA5 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CAX = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CC2 = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CC4 = 3'd5;
  localparam logic [PHASE_W-1:0] PH_CC6 = 3'd6;
  localparam logic [PHASE_W-1:0] PH_CCX = 3'd7;

  // pin layouts, shared by an anode phase and its cathode partner
  localparam logic [1:0] LAYOUT_1 = 2'd0;
  localparam logic [1:0] LAYOUT_3 = 2'd1;
  localparam logic [1:0] LAYOUT_5 = 2'd2;
  localparam logic [1:0] LAYOUT_X = 2'd3;

  // common pins on port c
  localparam logic [PORT_W-1:0] PIN_COMMON_1 = 8'h10;
  localparam logic [PORT_W-1:0] PIN_COMMON_3 = 8'h08;
  localparam logic [PORT_W-1:0] PIN_COMMON_5 = 8'h04;
  localparam logic [PORT_W-1:0] PIN_COMMON_X = 8'h02;

  // pins that are not wired to the display
  localparam logic [PORT_W-1:0] PORT_C_UNUSED = 8'hE1;
  localparam logic [PORT_W-1:0] PORT_D_UNUSED = 8'h62;

  typedef struct packed {
    logic [SEG_W-1:0] top_tens;
    logic [SEG_W-1:0] top_ones;
    logic [SEG_W-1:0] top_tenths;
    logic [SEG_W-1:0] bottom_tens;
    logic [SEG_W-1:0] bottom_ones;
    logic [SEG_W-1:0] bottom_tenths;
  } digits_t;

  typedef struct packed {
    logic [PORT_W-1:0] c_drive;
    logic [PORT_W-1:0] c_level;
    logic [PORT_W-1:0] d_drive;
    logic [PORT_W-1:0] d_level;
  } pins_t;

endpackage

`default_nettype wire

// ===== sv/ccss_pin_map.sv =====
// ----------------------------------------------------------------------------
// ccss_pin_map
// maps one phase's segment bytes onto port c / port d drive and level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccss_pin_map (
  input  ccss_pkg::digits_t                  digits,
  input  logic [ccss_pkg::PHASE_W-1:0]       phase,
  output ccss_pkg::pins_t                    pins
);
  import ccss_pkg::*;

  typedef struct packed {
    logic [PORT_W-1:0] c;
    logic [PORT_W-1:0] d;
  } port_pair_t;

  function automatic port_pair_t map_pins(input logic [1:0] layout,
                                          input logic [SEG_W-1:0] p,
                                          input logic [SEG_W-1:0] q);
    port_pair_t r;
    r = '0;
    case (layout)
      LAYOUT_1: begin
        r.c[3]   = p[7];
        r.c[2]   = p[6];
        r.c[1]   = p[4];
        r.d[7]   = p[5];
        r.d[4:2] = p[3:1];
        r.d[0]   = p[0];
      end
      LAYOUT_3: begin
        r.c[2]   = p[7];
        r.c[1]   = p[5];
        r.d[7]   = p[6];
        r.d[4:2] = p[4:2];
        r.d[0]   = p[1];
      end
      LAYOUT_5: begin
        r.c[1]   = p[6];
        r.d[7]   = p[7];
        r.d[4:2] = p[5:3];
        r.d[0]   = p[2];
      end
      default: begin
        // extra phase: dp of one digit, g and dp of another
        r.d[4]   = p[0];
        r.d[3:2] = q[1:0];
      end
    endcase
    return r;
  endfunction

  logic [1:0]        layout;
  logic              anode;
  logic [SEG_W-1:0]  p_sel;
  logic [SEG_W-1:0]  q_sel;
  logic [PORT_W-1:0] common;
  port_pair_t        drv_map;
  port_pair_t        lvl_map;

  assign layout = phase[1:0];
  assign anode  = ~phase[2];

  always_comb begin
    p_sel = digits.top_tens;
    q_sel = '0;
    case (phase)
      PH_CA1: p_sel = digits.top_tens;
      PH_CA3: p_sel = digits.top_tenths;
      PH_CA5: p_sel = digits.bottom_ones;
      PH_CAX: begin
        p_sel = digits.top_tenths;
        q_sel = digits.bottom_ones;
      end
      PH_CC2: p_sel = digits.top_ones;
      PH_CC4: p_sel = digits.bottom_tens;
      PH_CC6: p_sel = digits.bottom_tenths;
      PH_CCX: begin
        p_sel = digits.bottom_tens;
        q_sel = digits.bottom_tenths;
      end
      default: p_sel = digits.top_tens;
    endcase
  end

  always_comb begin
    case (layout)
      LAYOUT_1: common = PIN_COMMON_1;
      LAYOUT_3: common = PIN_COMMON_3;
      LAYOUT_5: common = PIN_COMMON_5;
      default:  common = PIN_COMMON_X;
    endcase
  end

  always_comb begin
    drv_map = map_pins(layout, p_sel, q_sel);
    // anode phases sink the segments, so levels come from the inverted bits
    lvl_map = anode ? map_pins(layout, ~p_sel, ~q_sel)
                    : map_pins(layout, p_sel, q_sel);
    pins.c_drive = drv_map.c | common;
    pins.d_drive = drv_map.d;
    pins.d_level = lvl_map.d & drv_map.d;
    if (anode) begin
      pins.c_level = (lvl_map.c & pins.c_drive) | common;
    end else begin
      pins.c_level = lvl_map.c & pins.c_drive & ~common;
    end
  end

endmodule

`default_nettype wire

// ===== sv/charlieplexed_seven_segment_scanner.sv =====
// ----------------------------------------------------------------------------
// charlieplexed_seven_segment_scanner
// steps through eight anode/cathode phases and gives pin drive and level
// ----------------------------------------------------------------------------
//
//  channel | ports                                       | one word
//  --------+---------------------------------------------+------------------------
//  in      | in_valid/in_ready, six segment bytes        | one scan tick
//  out     | out_valid/out_ready, port c/d drive + level | pins for one phase
//
//  two register stages: an input register holding the segment bytes and the
//  phase, then the result register; the pin mapping sits between them
//  one word per cycle sustained while out_ready is high; out_valid is registered
//  each stage loads whenever it is empty or the stage after it is draining,
//  so a tick is still taken while one finished result waits on out_ready
//  reset clears both valid flags and puts the phase counter on the first
//  anode phase; the phase advances once per accepted tick
//
`timescale 1ns / 1ps
`default_nettype none

module charlieplexed_seven_segment_scanner (
  input  logic                               clk,
  input  logic                               rst_n,
  // tick input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ccss_pkg::SEG_W-1:0]         in_top_tens,
  input  logic [ccss_pkg::SEG_W-1:0]         in_top_ones,
  input  logic [ccss_pkg::SEG_W-1:0]         in_top_tenths,
  input  logic [ccss_pkg::SEG_W-1:0]         in_bottom_tens,
  input  logic [ccss_pkg::SEG_W-1:0]         in_bottom_ones,
  input  logic [ccss_pkg::SEG_W-1:0]         in_bottom_tenths,
  // pin result
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ccss_pkg::PORT_W-1:0]        out_port_c_drive,
  output logic [ccss_pkg::PORT_W-1:0]        out_port_c_level,
  output logic [ccss_pkg::PORT_W-1:0]        out_port_d_drive,
  output logic [ccss_pkg::PORT_W-1:0]        out_port_d_level,
  output logic [ccss_pkg::PHASE_W-1:0]       out_phase_shown
);
  import ccss_pkg::*;

  // scan phase counter, advances on every accepted tick
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;

  // input stage
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  digits_t            s1_digits_r;
  logic [PHASE_W-1:0] s1_phase_r;

  // result stage
  logic               s2_valid_r;
  logic               s2_valid_nxt;
  pins_t              s2_pins_r;
  logic [PHASE_W-1:0] s2_phase_r;

  logic    in_fire;
  logic    s2_load;
  pins_t   map_pins_w;
  digits_t in_digits;

  assign s2_load  = s1_valid_r & (~s2_valid_r | out_ready);
  // stage 1 can take a word when empty or when it hands its word on
  assign in_ready = ~s1_valid_r | s2_load;
  assign in_fire  = in_valid & in_ready;

  assign in_digits.top_tens      = in_top_tens;
  assign in_digits.top_ones      = in_top_ones;
  assign in_digits.top_tenths    = in_top_tenths;
  assign in_digits.bottom_tens   = in_bottom_tens;
  assign in_digits.bottom_ones   = in_bottom_ones;
  assign in_digits.bottom_tenths = in_bottom_tenths;

  // wraps from the last cathode phase back to the first anode phase
  assign phase_nxt    = in_fire ? phase_r + 3'd1 : phase_r;
  assign s1_valid_nxt = in_fire | (s1_valid_r & ~s2_load);
  assign s2_valid_nxt = s2_load | (s2_valid_r & ~out_ready);

  ccss_pin_map u_pin_map (
    .digits (s1_digits_r),
    .phase  (s1_phase_r),
    .pins   (map_pins_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CA1;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_digits_r <= in_digits;
      s1_phase_r  <= phase_r;
    end
    if (s2_load) begin
      s2_pins_r  <= map_pins_w;
      s2_phase_r <= s1_phase_r;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_port_c_drive = s2_pins_r.c_drive;
  assign out_port_c_level = s2_pins_r.c_level;
  assign out_port_d_drive = s2_pins_r.d_drive;
  assign out_port_d_level = s2_pins_r.d_level;
  assign out_phase_shown  = s2_phase_r;

  // phase moves by exactly one per accepted tick
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> phase_r == $past(phase_r) + 3'd1)
    else $error("scan phase did not advance by one");

  // a pin is never high unless it is driven
  a_level_in_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_port_c_level & ~out_port_c_drive) == '0)
               && ((out_port_d_level & ~out_port_d_drive) == '0))
    else $error("level set on an undriven pin");

  // pins outside the display stay quiet
  a_unused_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_port_c_drive & PORT_C_UNUSED) == '0)
               && ((out_port_d_drive & PORT_D_UNUSED) == '0))
    else $error("unused pin driven");

  // an empty input stage always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while empty");

endmodule

`default_nettype wire
